/* rtl/frame_energy_voice_detector_assert.svh */
`ifndef FRAME_ENERGY_VOICE_DETECTOR_ASSERT_SVH
`define FRAME_ENERGY_VOICE_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FEVD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FEVD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/fevd_pkg.sv */
package fevd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int THR_W      = 31;
	localparam int HANG_CFG_W = 20;
	localparam int SQ_W       = 31;   // (-32768)^2 = 2^30 needs 31 bits
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 3;

	localparam logic [THR_W-1:0]      THR_RESET  = 31'd327642;
	localparam logic [HANG_CFG_W-1:0] HANG_RESET = 20'd6400;

	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_THR  = 1'b0;
	localparam reg_idx_t REG_HANG = 1'b1;

endpackage

/* rtl/frame_energy_voice_detector.sv */
// Frame energy voice activity detector.
// Input channel: one signed 16-bit PCM sample per beat (sample, frame_end),
// handshake sample_valid/sample_ready. frame_end marks the last sample of a frame.
// Output channel: one beat per frame (voice_active, above_threshold), handshake
// result_valid/result_ready. Samples without frame_end produce no beat.
// A frame is speech when its sum of squares exceeds energy_threshold_sq times
// its sample count; speech reloads the hangover, quiet frames drain it by the
// frame length. Samples past MAX_FRAME_SAMPLES in one frame are dropped.
// Throughput: one sample per cycle unless a frame end is stalled, set by the
// square and accumulate stages. The result beat for the accepted frame_end sample
// passes input reg, square, accumulate, threshold multiply and output registers.
// Stall: each stage holds its own valid bit, so while a result waits on
// result_ready the block keeps taking samples until the stages in front of it
// fill; mid-frame samples retire into the accumulator and never block.
// Reset (arst_n low): accumulators, hangover and all valid bits clear;
// registers return to energy_threshold_sq = 327642, hangover_samples = 6400.
// Config (APB, pready tied high): reg 0 at 0x0, reg 1 at 0x4; write only when idle.
module frame_energy_voice_detector #(
	parameter int MAX_FRAME_SAMPLES = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [fevd_pkg::SAMPLE_W-1:0] sample,
	input  logic                             frame_end,
	input  logic                             sample_valid,
	output logic                             sample_ready,
	output logic                             voice_active,
	output logic                             above_threshold,
	output logic                             result_valid,
	input  logic                             result_ready,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [fevd_pkg::ADDR_W-1:0]      paddr,
	input  logic [fevd_pkg::DATA_W-1:0]      pwdata,
	output logic [fevd_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);
	import fevd_pkg::*;

	`include "frame_energy_voice_detector_assert.svh"

	// Count must hold MAX_FRAME_SAMPLES itself.
	localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int SUM_W  = SQ_W - 1 + CNT_W;
	localparam int PROD_W = THR_W + CNT_W;
	// Hangover spans +hangover_samples down to just above -MAX_FRAME_SAMPLES.
	localparam int HANG_W = (CNT_W + 1 > HANG_CFG_W + 1) ? CNT_W + 1 : HANG_CFG_W + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_SAMPLES);

	// ---------------- configuration registers ----------------
	logic [THR_W-1:0]      thr_q;
	logic [HANG_CFG_W-1:0] hang_cfg_q;
	logic                  cfg_wr;
	reg_idx_t              cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[2:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= THR_RESET;
			hang_cfg_q <= HANG_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_THR:  thr_q      <= pwdata[THR_W-1:0];
				REG_HANG: hang_cfg_q <= pwdata[HANG_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_THR:  prdata = DATA_W'(thr_q);
			REG_HANG: prdata = DATA_W'(hang_cfg_q);
			default:  prdata = '0;
		endcase
	end

	// ---------------- pipeline registers ----------------
	logic                       v_s1, v_s2, v_s3, v_s4;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       end_s1, end_s2;
	logic [SQ_W-1:0]            sq_s2;
	logic [SUM_W-1:0]           sum_s3, sum_s4;
	logic [CNT_W-1:0]           cnt_s3, cnt_s4;
	logic [PROD_W-1:0]          prod_s4;

	logic [SUM_W-1:0]           sum_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [HANG_W-1:0]   hang_q;
	logic                       out_valid_q, active_q, above_q;

	// Per-stage advance: a stage moves when the one ahead is empty or moving.
	logic go1, go2, go3, go_out;
	logic take2, take3, take4;

	assign go_out = v_s4 && (!out_valid_q || result_ready);
	assign take4  = !v_s4 || go_out;
	assign go3    = v_s3 && take4;
	assign take3  = !v_s3 || go3;
	// Mid-frame samples retire into the accumulator, so only a frame end can stall.
	assign go2    = v_s2 && (!end_s2 || take3);
	assign take2  = !v_s2 || go2;
	assign go1    = v_s1 && take2;

	assign sample_ready = !v_s1 || go1;

	// Square of the sample; always non-negative and at most 2^30.
	logic signed [2*SAMPLE_W-1:0] sq_full;
	assign sq_full = sample_s1 * sample_s1;

	// Accumulate unless the frame has already hit its sample limit.
	logic             room;
	logic [SUM_W-1:0] sum_add;
	logic [CNT_W-1:0] cnt_add;

	assign room    = cnt_q < CNT_MAX;
	assign sum_add = room ? sum_q + SUM_W'(sq_s2) : sum_q;
	assign cnt_add = room ? cnt_q + CNT_W'(1) : cnt_q;

	// Frame decision and hangover update.
	logic                     above;
	logic signed [HANG_W-1:0] hang_next;
	logic                     active;

	assign above = PROD_W'(sum_s4) > prod_s4;

	always_comb begin
		hang_next = hang_q;
		active    = 1'b1;
		if (above) begin
			hang_next = HANG_W'(hang_cfg_q);
		end else if (hang_q > 0) begin
			hang_next = hang_q - $signed(HANG_W'(cnt_s4));
		end else begin
			active = 1'b0;
		end
	end

	// Valid bits and state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			hang_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample_ready) begin
				v_s1 <= sample_valid;
			end
			if (take2) begin
				v_s2 <= go1;
			end
			if (go2) begin
				sum_q <= end_s2 ? '0 : sum_add;
				cnt_q <= end_s2 ? '0 : cnt_add;
			end
			if (take3) begin
				v_s3 <= go2 && end_s2;
			end
			if (take4) begin
				v_s4 <= go3;
			end
			if (go_out) begin
				hang_q      <= hang_next;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: loaded only when the stage takes a beat.
	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
			end_s1    <= frame_end;
		end
		if (go1) begin
			sq_s2  <= sq_full[SQ_W-1:0];
			end_s2 <= end_s1;
		end
		if (go2 && end_s2) begin
			sum_s3 <= sum_add;
			cnt_s3 <= cnt_add;
		end
		if (go3) begin
			sum_s4  <= sum_s3;
			cnt_s4  <= cnt_s3;
			prod_s4 <= PROD_W'(thr_q) * PROD_W'(cnt_s3);
		end
		if (go_out) begin
			active_q <= active;
			above_q  <= above;
		end
	end

	assign result_valid    = out_valid_q;
	assign voice_active    = active_q;
	assign above_threshold = above_q;

	// ---------------- assertions ----------------
	`FEVD_ASSERT_IMP(a_cnt_limit, 1'b1, cnt_q <= CNT_MAX, "frame count past limit")
	`FEVD_ASSERT_IMP(a_no_empty_frame, v_s3, cnt_s3 != '0, "frame end with zero samples")
	`FEVD_ASSERT_NXT(a_hang_reload, go_out && above,
		hang_q == HANG_W'($past(hang_cfg_q)), "hangover not reloaded on speech")
	`FEVD_ASSERT_IMP(a_quiet_implies_below, result_valid && !voice_active,
		!above_threshold, "inactive beat marked above threshold")

endmodule
